// File: design/command_frame_builder_top_macros.svh
// Assertion macros shared by the checker of the command frame builder.
`ifndef COMMAND_FRAME_BUILDER_TOP_MACROS_SVH
`define COMMAND_FRAME_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define CFB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfb assertion failed");

// Next-cycle implication, sampled on clk, off while reset is asserted
`define CFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfb assertion failed");

`endif

// File: design/cfb_pkg.sv
// Package: constants, step codes and result type of the command frame builder.
`default_nettype none

package cfb_pkg;

    localparam logic [15:0] MAX_PAYLOAD = 16'd100;
    localparam int          LEFT_W      = 7;
    localparam logic [7:0]  HEAD_A      = 8'h59;
    localparam logic [7:0]  HEAD_B      = 8'h4D;

    // Position of the next result within the item's expansion
    typedef logic [3:0] cfb_step_t;
    localparam cfb_step_t STEP_HEAD_A = 4'd0;
    localparam cfb_step_t STEP_HEAD_B = 4'd1;
    localparam cfb_step_t STEP_CMD    = 4'd2;
    localparam cfb_step_t STEP_SEQ_LO = 4'd3;
    localparam cfb_step_t STEP_SEQ_HI = 4'd4;
    localparam cfb_step_t STEP_LEN_LO = 4'd5;
    localparam cfb_step_t STEP_LEN_HI = 4'd6;
    localparam cfb_step_t STEP_DATA   = 4'd7;
    localparam cfb_step_t STEP_SUM    = 4'd8;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_DATA,
        KIND_SUM,
        KIND_ERR
    } cfb_kind_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       status;
    } cfb_result_t;

endpackage

`default_nettype wire

// File: design/cfb_if.sv
// Valid/ready channel interfaces for input items and frame bytes.
`default_nettype none

interface cfb_item_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic [7:0]  cmd;
    logic [15:0] body_len;
    logic        has_data;
    logic [7:0]  data_byte;

    modport source (output valid, start_req, cmd, body_len, has_data, data_byte,
                    input ready);
    modport sink   (input valid, start_req, cmd, body_len, has_data, data_byte,
                    output ready);
endinterface

interface cfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       status;

    modport source (output valid, out_byte, frame_end, status, input ready);
    modport sink   (input valid, out_byte, frame_end, status, output ready);
endinterface

`default_nettype wire

// File: design/cfb_seq.sv
// Item register, frame state and per-step result selection.
`default_nettype none

module cfb_seq
    import cfb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfb_item_if.sink   item_ch,
    input  wire logic  can_load,
    output logic       push,
    output cfb_result_t result
);

    // Held item
    logic        busy_reg, busy_next;
    cfb_step_t   step_reg, step_next;
    logic        start_reg;
    logic [7:0]  cmd_reg;
    logic [15:0] len_reg;
    logic        has_data_reg;
    logic [7:0]  data_reg;

    // Frame state
    logic [15:0]       seq_reg, seq_next;
    logic [7:0]        sum_reg, sum_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              open_reg, open_next;

    cfb_kind_t   kind;
    logic [7:0]  hdr_byte;
    logic        last;
    logic        fire;
    logic        accept;
    logic        load;

    // Decode the current step into a result kind
    always_comb
    begin
        kind     = KIND_HDR;
        hdr_byte = HEAD_A;
        last     = 1'b0;
        unique case (step_reg)
            STEP_HEAD_A:
            begin
                if (start_reg && (len_reg > MAX_PAYLOAD))
                begin
                    kind = KIND_ERR;
                    last = 1'b1;
                end
            end
            STEP_HEAD_B: hdr_byte = HEAD_B;
            STEP_CMD:    hdr_byte = cmd_reg;
            STEP_SEQ_LO: hdr_byte = seq_reg[7:0];
            STEP_SEQ_HI: hdr_byte = seq_reg[15:8];
            STEP_LEN_LO: hdr_byte = len_reg[7:0];
            STEP_LEN_HI:
            begin
                hdr_byte = len_reg[15:8];
                last     = (len_reg != 16'd0) && !has_data_reg;
            end
            STEP_DATA:
            begin
                if (start_reg && (left_reg == '0))
                begin
                    kind = KIND_SUM;
                    last = 1'b1;
                end
                else if (!start_reg && (!open_reg || (left_reg == '0)))
                begin
                    kind = KIND_ERR;
                    last = 1'b1;
                end
                else
                begin
                    kind = KIND_DATA;
                    last = (left_reg != LEFT_W'(1));
                end
            end
            STEP_SUM:
            begin
                kind = KIND_SUM;
                last = 1'b1;
            end
            default:
            begin
                kind = KIND_ERR;
                last = 1'b1;
            end
        endcase
    end

    // Result payload
    always_comb
    begin
        result = '{out_byte: hdr_byte, frame_end: 1'b0, status: STATUS_OK};
        case (kind)
            KIND_DATA: result.out_byte = data_reg;
            KIND_SUM:
            begin
                result.out_byte  = sum_reg;
                result.frame_end = 1'b1;
            end
            KIND_ERR:
            begin
                result.out_byte = 8'h00;
                result.status   = STATUS_ERR;
            end
            default: ;
        endcase
    end

    assign fire          = busy_reg && can_load;
    assign push          = fire;
    assign item_ch.ready = !busy_reg || (fire && last);
    assign accept        = item_ch.valid && item_ch.ready;
    // Idle items give no result and are dropped on accept
    assign load          = accept && (item_ch.start_req || item_ch.has_data);

    // Item control
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (fire)
        begin
            step_next = step_reg + cfb_step_t'(1);
            if (last)
                busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            step_next = item_ch.start_req ? STEP_HEAD_A : STEP_DATA;
        end
    end

    // Frame state updates per emitted result
    always_comb
    begin
        seq_next  = seq_reg;
        sum_next  = sum_reg;
        left_next = left_reg;
        open_next = open_reg;
        if (fire)
        begin
            case (kind)
                KIND_HDR:
                begin
                    if (step_reg == STEP_HEAD_A)
                    begin
                        sum_next  = HEAD_A;
                        open_next = 1'b1;
                        left_next = len_reg[LEFT_W-1:0];
                    end
                    else
                        sum_next = sum_reg + hdr_byte;
                end
                KIND_DATA:
                begin
                    sum_next  = sum_reg + data_reg;
                    left_next = left_reg - LEFT_W'(1);
                end
                KIND_SUM:
                begin
                    sum_next  = 8'h00;
                    left_next = '0;
                    open_next = 1'b0;
                    seq_next  = seq_reg + 16'd1;
                end
                default: ;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_HEAD_A;
            seq_reg  <= '0;
            sum_reg  <= '0;
            left_reg <= '0;
            open_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            seq_reg  <= seq_next;
            sum_reg  <= sum_next;
            left_reg <= left_next;
            open_reg <= open_next;
        end
    end

    // Item payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            start_reg    <= item_ch.start_req;
            cmd_reg      <= item_ch.cmd;
            len_reg      <= item_ch.body_len;
            has_data_reg <= item_ch.has_data;
            data_reg     <= item_ch.data_byte;
        end
    end

endmodule

`default_nettype wire

// File: design/cfb_out_stage.sv
// Output register between the step logic and the frame byte channel.
`default_nettype none

module cfb_out_stage
    import cfb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  cfb_result_t result,
    output logic       can_load,
    cfb_frame_if.source frame_ch
);

    logic        valid_reg;
    cfb_result_t data_reg;

    assign can_load = !valid_reg || frame_ch.ready;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= push;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (can_load && push)
            data_reg <= result;
    end

    assign frame_ch.valid     = valid_reg;
    assign frame_ch.out_byte  = data_reg.out_byte;
    assign frame_ch.frame_end = data_reg.frame_end;
    assign frame_ch.status    = data_reg.status;

endmodule

`default_nettype wire

// File: design/command_frame_builder_top.sv
// Top level of the command frame builder.
// Usage:
//   item_ch  : input items (start_req, cmd, body_len, has_data, data_byte).
//              A start item opens a frame; a data item carries one payload byte.
//   frame_ch : frame bytes built from the items on this channel, with frame_end on the
//              closing checksum byte and status=1 on an over-limit length or stray data.
// Path: item register, then step logic, then output register to frame_ch.
// Throughput: the byte stage emits one result per cycle while the output
//   register can take it, and an item holds the block until its results have
//   gone: 1 result for a payload byte, 2 for the last payload byte (byte plus
//   checksum), 7 to 9 for a start item, 1 for an error. Items that yield
//   nothing are dropped on accept. A new item is accepted in the same cycle
//   as the last result of the held item moves to the output register.
// Reset: clears sequence number, checksum, open frame and all valid flags.
// Stall: while frame_ch.ready is low and a byte is offered, the output register
//   holds it, the step logic waits, and item_ch.ready drops once an item is held.
`default_nettype none

module command_frame_builder_top
    import cfb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfb_item_if.sink    item_ch,
    cfb_frame_if.source frame_ch
);

    logic        push;
    logic        can_load;
    cfb_result_t result;

    cfb_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_ch  (item_ch),
        .can_load (can_load),
        .push     (push),
        .result   (result)
    );

    cfb_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .result   (result),
        .can_load (can_load),
        .frame_ch (frame_ch)
    );

endmodule

`default_nettype wire

// File: design/cfb_checker.sv
// Port-level checker for the command frame builder and its bind.
`default_nettype none
`include "command_frame_builder_top_macros.svh"

module cfb_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       frame_end,
    input wire logic       status
);

    // Error results carry no byte and never close a frame
    `CFB_ASSERT_IMPL(a_err_zero, out_valid && status, (out_byte == 8'h00) && !frame_end)
    // Checksum byte is always ok
    `CFB_ASSERT_IMPL(a_end_ok, out_valid && frame_end, !status)
    // A stalled byte stays offered
    `CFB_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)
    // A stalled byte keeps its payload
    `CFB_ASSERT_NEXT(a_hold_data, out_valid && !out_ready,
        $stable(out_byte) && $stable(frame_end) && $stable(status))

endmodule

bind command_frame_builder_top cfb_checker u_cfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (frame_ch.valid),
    .out_ready (frame_ch.ready),
    .out_byte  (frame_ch.out_byte),
    .frame_end (frame_ch.frame_end),
    .status    (frame_ch.status)
);

`default_nettype wire

// File: tb/tb.sv
// Testbench of the command frame builder: frame byte prediction and handshake stimulus.
`timescale 1ns / 1ps

module tb;
    import cfb_pkg::*;

    // One input item as offered on the item channel
    typedef struct packed {
        logic        start_req;
        logic [7:0]  cmd;
        logic [15:0] body_len;
        logic        has_data;
        logic [7:0]  data_byte;
    } cmd_item_t;

    // Frame state copy and the bytes still owed by the block
    class frame_checker;
        logic [15:0]       seq_num;
        logic [7:0]        byte_sum;
        logic [LEFT_W-1:0] payload_left;
        logic              in_frame;
        cfb_result_t       expected_bytes[$];
        int                failures;

        function new();
            seq_num      = '0;
            byte_sum     = '0;
            payload_left = '0;
            in_frame     = 1'b0;
            failures     = 0;
        endfunction

        function void push_byte(logic [7:0] value);
            cfb_result_t r;
            r.out_byte  = value;
            r.frame_end = 1'b0;
            r.status    = STATUS_OK;
            expected_bytes.push_back(r);
            byte_sum = byte_sum + value;
        endfunction

        function void push_error();
            cfb_result_t r;
            r.out_byte  = 8'h00;
            r.frame_end = 1'b0;
            r.status    = STATUS_ERR;
            expected_bytes.push_back(r);
        endfunction

        // Checksum closes the frame and advances the sequence number
        function void push_checksum();
            cfb_result_t r;
            r.out_byte  = byte_sum;
            r.frame_end = 1'b1;
            r.status    = STATUS_OK;
            expected_bytes.push_back(r);
            in_frame     = 1'b0;
            payload_left = '0;
            byte_sum     = '0;
            seq_num      = seq_num + 16'd1;
        endfunction

        function void take_payload(logic [7:0] value);
            push_byte(value);
            payload_left = payload_left - LEFT_W'(1);
            if (payload_left == 0)
                push_checksum();
        endfunction

        // Expected bytes caused by one accepted item
        function void expand_item(cmd_item_t it);
            if (it.start_req) begin
                if (it.body_len > MAX_PAYLOAD) begin
                    push_error();
                    return;
                end
                // a start over an open frame simply abandons it
                byte_sum     = '0;
                in_frame     = 1'b1;
                payload_left = it.body_len[LEFT_W-1:0];
                push_byte(HEAD_A);
                push_byte(HEAD_B);
                push_byte(it.cmd);
                push_byte(seq_num[7:0]);
                push_byte(seq_num[15:8]);
                push_byte(it.body_len[7:0]);
                push_byte(it.body_len[15:8]);
                if (payload_left == 0)
                    push_checksum();
                else if (it.has_data)
                    take_payload(it.data_byte);
                return;
            end
            if (!it.has_data)
                return;
            if (!in_frame || payload_left == 0)
                push_error();
            else
                take_payload(it.data_byte);
        endfunction

        function void check_byte(cfb_result_t got);
            cfb_result_t want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected frame byte %0h (frame_end %0b, status %0b)",
                       got.out_byte, got.frame_end, got.status);
                failures++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                failures++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0b, actual %0b", want.status, got.status);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cfb_item_if  item_ch();
    cfb_frame_if frame_ch();

    command_frame_builder_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_ch  (item_ch),
        .frame_ch (frame_ch)
    );

    frame_checker book;
    int           items_sent;
    int           src_idle_pct;
    int           sink_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure
    initial
    begin
        frame_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            frame_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && frame_ch.valid && frame_ch.ready)
            book.check_byte(cfb_result_t'({frame_ch.out_byte, frame_ch.frame_end,
                                           frame_ch.status}));
    end

    // Offer one item, idling first at random, and note it once accepted
    task automatic offer_item(input logic start_req, input logic [7:0] cmd,
                              input logic [15:0] body_len, input logic has_data,
                              input logic [7:0] data_byte);
        cmd_item_t it;
        it = {start_req, cmd, body_len, has_data, data_byte};
        if (items_sent < 160) begin
            src_idle_pct   = 14;
            sink_stall_pct = 76;
        end
        else if (items_sent < 320) begin
            src_idle_pct   = 76;
            sink_stall_pct = 14;
        end
        else begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.start_req <= it.start_req;
        item_ch.cmd       <= it.cmd;
        item_ch.body_len  <= it.body_len;
        item_ch.has_data  <= it.has_data;
        item_ch.data_byte <= it.data_byte;
        do
            @(posedge clk);
        while (!item_ch.ready);
        book.expand_item(it);
        if (it.start_req || it.has_data)
            items_sent++;
    endtask

    // Idle item with junk in the ignored fields
    task automatic offer_idle();
        offer_item(1'b0, 8'($urandom), 16'($urandom), 1'b0, 8'($urandom));
    endtask

    initial
    begin
        int sel;
        int len;
        int stop_at;
        book           = new();
        items_sent     = 0;
        src_idle_pct   = 14;
        sink_stall_pct = 76;
        rst_n              = 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.start_req  <= 1'b0;
        item_ch.cmd        <= 8'h00;
        item_ch.body_len   <= 16'h0000;
        item_ch.has_data   <= 1'b0;
        item_ch.data_byte  <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: data with no frame open, idle item
        offer_item(1'b0, 8'h00, 16'd0, 1'b1, 8'hFF);
        offer_idle();
        // empty payload; the data byte on the start is ignored
        offer_item(1'b1, 8'h00, 16'd0, 1'b1, 8'hAA);
        // length too large, just over the limit and at the top of the range
        offer_item(1'b1, 8'h33, MAX_PAYLOAD + 16'd1, 1'b1, 8'h55);
        offer_item(1'b1, 8'hFF, 16'hFFFF, 1'b0, 8'h00);
        // single payload byte carried by the start item
        offer_item(1'b1, 8'hFF, 16'd1, 1'b1, 8'hFF);
        // frame abandoned by a new start, which then completes
        offer_item(1'b1, 8'h5A, 16'd3, 1'b0, 8'h00);
        offer_item(1'b0, 8'hFF, 16'hFFFF, 1'b1, 8'h00);
        offer_idle();
        offer_item(1'b1, 8'h01, 16'd2, 1'b1, 8'h80);
        offer_item(1'b0, 8'h00, 16'd0, 1'b1, 8'h7F);
        // data after a closed frame
        offer_item(1'b0, 8'h00, 16'd0, 1'b1, 8'h01);
        // open frame with payload pending, abandoned by an empty frame
        offer_item(1'b1, 8'hC3, 16'd2, 1'b1, 8'h3C);
        offer_item(1'b1, 8'h80, 16'd0, 1'b0, 8'h00);
        // error start while a frame is open leaves that frame alive
        offer_item(1'b1, 8'h11, 16'd2, 1'b0, 8'h00);
        offer_item(1'b1, 8'h22, 16'h8000, 1'b1, 8'h99);
        offer_item(1'b0, 8'h00, 16'd0, 1'b1, 8'h12);
        offer_item(1'b0, 8'h00, 16'd0, 1'b1, 8'h34);

        // Random: mostly well-formed frames, some noise
        while (items_sent < 480)
        begin
            sel = $urandom_range(99);
            if (sel < 80) begin
                sel = $urandom_range(99);
                if (sel < 6)
                    len = MAX_PAYLOAD;
                else if (sel < 16)
                    len = 0;
                else if (sel < 26)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(1, 8);
                stop_at = len;
                if ($urandom_range(99) < 5)
                    stop_at = $urandom_range(0, len);
                sel = $urandom_range(1);
                offer_item(1'b1, 8'($urandom), 16'(len), sel[0], 8'($urandom));
                for (int i = sel; i < stop_at; i++)
                begin
                    if ($urandom_range(99) < 8)
                        offer_idle();
                    offer_item(1'b0, 8'($urandom), 16'($urandom), 1'b1, 8'($urandom));
                end
            end
            else if (sel < 90)
                offer_item(1'b1, 8'($urandom), 16'($urandom_range(101, 65535)),
                           1'($urandom), 8'($urandom));
            else if (sel < 96)
                offer_item(1'b0, 8'($urandom), 16'($urandom), 1'b1, 8'($urandom));
            else
                offer_idle();
        end
        item_ch.valid <= 1'b0;

        // Drain, then allow for the pipeline latency
        while (book.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (book.failures == 0 && book.expected_bytes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Run time limit
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/cfb_pkg.sv
design/cfb_if.sv
design/cfb_seq.sv
design/cfb_out_stage.sv
design/command_frame_builder_top.sv
design/cfb_checker.sv
tb/tb.sv
